/* rtl/mtf_pkg.sv */
// ----------------------------------------------------------------------------
// Move-to-front coder package
// Shared widths, register indexes, controller states and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtf_pkg;

  // Default alphabet size and fixed field widths.
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int SYM_W             = 8;
  localparam int MAP_W             = 256;
  localparam int MAP_WORD_W        = 64;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION = 3'd0,
    REG_MAP_0     = 3'd1,
    REG_MAP_1     = 3'd2,
    REG_MAP_2     = 3'd3,
    REG_MAP_3     = 3'd4
  } cfg_reg_t;

  // Coding direction.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_IDLE,
    ST_MATCH,
    ST_REDUCE,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_clear;
    logic load_step;
    logic match;
    logic reduce;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/mtf_in_if.sv */
// ----------------------------------------------------------------------------
// Move-to-front input channel
// Valid/ready channel that carries one input word: a byte or a position and
// the start-of-block flag.
// ----------------------------------------------------------------------------
interface mtf_in_if;
  import mtf_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] item_value;
  logic             start_of_block;

  modport source (output valid, item_value, start_of_block, input ready);
  modport sink   (input valid, item_value, start_of_block, output ready);

endinterface

/* rtl/mtf_out_if.sv */
// ----------------------------------------------------------------------------
// Move-to-front result channel
// Valid/ready channel that carries one result word: the coded value and the
// not-found flag.
// ----------------------------------------------------------------------------
interface mtf_out_if;
  import mtf_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] coded_value;
  logic             not_found;

  modport source (output valid, coded_value, not_found, input ready);
  modport sink   (input valid, coded_value, not_found, output ready);

endinterface

/* rtl/move_to_front_coder_top.sv */
// ----------------------------------------------------------------------------
// Move-to-front coder top level
// Encodes bytes to list positions or decodes positions to bytes over a list
// that is reloaded from a presence map at each start of block.
//
//   channel   role     handshake       payload
//   item      sink     valid/ready     item_value[7:0], start_of_block
//   result    source   valid/ready     coded_value[7:0], not_found
//   cfg       write    cfg_write       cfg_index[2:0], cfg_data[63:0]
//
// A word passes through accept, match across all list cells, reduction of
// the hit row, and commit of the shift and the result register.
// A word with start_of_block set adds the reload sweep over the presence
// map, one step per symbol.
// After reset the same sweep runs before the first word is accepted.
// A new word is accepted while a result waits; commit waits for the result
// register to be free.
// ----------------------------------------------------------------------------
module move_to_front_coder_top #(
  parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  mtf_in_if.sink                         item,
  mtf_out_if.source                      result,
  input  logic                           cfg_write,
  input  logic [mtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mtf_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic             direction;
  logic [MAP_W-1:0] present_map;

  // Configuration registers.
  mtf_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .direction   (direction),
    .present_map (present_map)
  );

  // Controller.
  mtf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_start (item.start_of_block),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath.
  mtf_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item_value  (item.item_value),
    .direction   (direction),
    .present_map (present_map),
    .result      (result)
  );

endmodule

/* rtl/mtf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Move-to-front configuration registers
// Holds the coding direction and the 256-bit symbol presence map.
// ----------------------------------------------------------------------------
module mtf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          direction,
  output logic [mtf_pkg::MAP_W-1:0]      present_map
);
  import mtf_pkg::*;

  logic [MAP_WORD_W-1:0] map_0;
  logic [MAP_WORD_W-1:0] map_1;
  logic [MAP_WORD_W-1:0] map_2;
  logic [MAP_WORD_W-1:0] map_3;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      map_0     <= '1;
      map_1     <= '1;
      map_2     <= '1;
      map_3     <= '1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIRECTION: direction <= cfg_data[0];
        REG_MAP_0:     map_0     <= cfg_data;
        REG_MAP_1:     map_1     <= cfg_data;
        REG_MAP_2:     map_2     <= cfg_data;
        REG_MAP_3:     map_3     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign present_map = {map_3, map_2, map_1, map_0};

endmodule

/* rtl/mtf_ctrl.sv */
// ----------------------------------------------------------------------------
// Move-to-front controller
// Sequences list reload, match, reduce and commit for one word at a time.
// ----------------------------------------------------------------------------
module mtf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_start,
  output logic             item_ready,
  input  mtf_pkg::status_t status,
  output mtf_pkg::cmd_t    cmd
);
  import mtf_pkg::*;

  state_t state;
  state_t state_next;
  logic   held;
  logic   held_next;

  // State register; reset starts with a list load from the reset map.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      held  <= 1'b0;
    end else begin
      state <= state_next;
      held  <= held_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    held_next  = held;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (status.load_last) begin
          state_next = held ? ST_MATCH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture    = 1'b1;
          cmd.load_clear = item_start;
          held_next      = 1'b1;
          state_next     = item_start ? ST_LOAD : ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match  = 1'b1;
        state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          held_next  = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/mtf_datapath.sv */
// ----------------------------------------------------------------------------
// Move-to-front datapath
// A row of list cells with per-cell compare and shift, the reload sweep,
// the hit reduction and the result register.
// ----------------------------------------------------------------------------
module mtf_datapath #(
  parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF,
  parameter int IDX_W         = $clog2(ALPHABET_SIZE),
  parameter int LEN_W         = $clog2(ALPHABET_SIZE + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mtf_pkg::cmd_t             cmd,
  output mtf_pkg::status_t          status,
  input  logic [mtf_pkg::SYM_W-1:0] item_value,
  input  logic                      direction,
  input  logic [mtf_pkg::MAP_W-1:0] present_map,
  mtf_out_if.source                 result
);
  import mtf_pkg::*;

  logic [SYM_W-1:0]         order [ALPHABET_SIZE];
  logic [LEN_W-1:0]         len;
  logic [IDX_W-1:0]         cnt;
  logic [SYM_W-1:0]         value;
  logic [ALPHABET_SIZE-1:0] hit;
  logic [ALPHABET_SIZE-1:0] alpha_map;
  logic [IDX_W-1:0]         pos;
  logic [SYM_W-1:0]         sym;
  logic                     found;
  logic [IDX_W-1:0]         pos_or;
  logic [SYM_W-1:0]         sym_or;

  assign alpha_map = present_map[ALPHABET_SIZE-1:0];

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value <= item_value;
    end
  end

  // Reload sweep counter and list length.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_clear) begin
      cnt <= '0;
      len <= '0;
    end else begin
      if (cmd.load_step) begin
        cnt <= cnt + 1'b1;
        if (alpha_map[cnt]) begin
          len <= len + 1'b1;
        end
      end
    end
  end

  assign status.load_last = (cnt == IDX_W'(ALPHABET_SIZE - 1));

  // List cells: append during reload, shift back on a move to the front.
  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.load_step && alpha_map[cnt] && (LEN_W'(k) == len)) begin
        order[k] <= SYM_W'(cnt);
      end else if (cmd.commit && found && (IDX_W'(k) <= pos)) begin
        if (k == 0) begin
          order[k] <= sym;
        end else begin
          order[k] <= order[(k == 0) ? 0 : k - 1];
        end
      end
    end

    // Per-cell match: symbol compare when encoding, index compare when decoding.
    always_ff @(posedge clk) begin
      if (cmd.match) begin
        if (direction == DIR_DECODE) begin
          hit[k] <= (SYM_W'(k) == value) && (LEN_W'(k) < len);
        end else begin
          hit[k] <= (order[k] == value) && (LEN_W'(k) < len);
        end
      end
    end
  end

  // Reduce the one-hot hit row to a position and a symbol.
  always_comb begin
    pos_or = '0;
    sym_or = '0;
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      pos_or = pos_or | (hit[k] ? IDX_W'(k) : '0);
      sym_or = sym_or | (hit[k] ? order[k] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reduce) begin
      pos   <= pos_or;
      sym   <= sym_or;
      found <= |hit;
    end
  end

  // Result register; freed when the sink takes the word.
  assign status.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.not_found <= !found;
      if (!found) begin
        result.coded_value <= '0;
      end else if (direction == DIR_DECODE) begin
        result.coded_value <= sym;
      end else begin
        result.coded_value <= SYM_W'(pos);
      end
    end
  end

  // The list never grows past the alphabet.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(ALPHABET_SIZE))
    else $error("list length beyond alphabet size");

  // Distinct list entries give at most one hit.
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    cmd.reduce |-> $onehot0(hit))
    else $error("more than one list cell matched");

  // A commit never overwrites a result that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("commit while result register is occupied");

  // An error result always carries a zero code.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.not_found) |-> (result.coded_value == '0))
    else $error("error result with nonzero code");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Move-to-front coder testbench
// Drives words through the item channel and checks every result word against
// a move-to-front list kept in the bench. A short table of directed words
// covers list extremes, both directions, empty and sparse maps, and both
// error cases. Randomized phases follow, with changing presence maps and
// directions and with sender and receiver idling in several patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtf_pkg::*;

  localparam int ALPHA       = ALPHABET_SIZE_DEF;
  localparam int IDLE_HEAVY  = 84;
  localparam int IDLE_LIGHT  = 20;
  localparam int N_PHASES    = 8;
  localparam int N_BLOCKS    = 7;
  localparam int BLOCK_WORDS = 20;
  localparam int DRAIN       = ALPHA + 16;
  localparam int MAX_REPORTS = 10;

  localparam logic [255:0] MAP_FULL   = '1;
  localparam logic [255:0] MAP_NONE   = '0;
  // Symbols 0, 127, 192 and 255 only.
  localparam logic [255:0] MAP_SPARSE =
    256'h8000000000000001_0000000000000000_8000000000000000_0000000000000001;
  // Symbol 200 only.
  localparam logic [255:0] MAP_ONE    =
    256'h0000000000000100_0000000000000000_0000000000000000_0000000000000000;

  typedef struct packed {
    logic [SYM_W-1:0] coded_value;
    logic             not_found;
  } code_t;

  typedef struct packed {
    logic             set_cfg;
    logic             dir;
    logic [255:0]     map;
    logic [SYM_W-1:0] value;
    logic             sob;
    logic             typed;
    logic [SYM_W-1:0] code;
    logic             nf;
  } directed_row_t;

  // Directed words: optional reconfiguration, the word, and where obvious the
  // expected result typed in.
  localparam int N_DIRECTED = 23;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, DIR_ENCODE, MAP_FULL,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
    '{1'b0, DIR_ENCODE, MAP_FULL,   8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
    '{1'b0, DIR_ENCODE, MAP_FULL,   8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
    '{1'b0, DIR_ENCODE, MAP_FULL,   8'd0,   1'b0, 1'b1, 8'd1,   1'b0},
    '{1'b0, DIR_ENCODE, MAP_FULL,   8'd128, 1'b1, 1'b1, 8'd128, 1'b0},
    '{1'b1, DIR_DECODE, MAP_FULL,   8'd0,   1'b0, 1'b1, 8'd128, 1'b0},
    '{1'b0, DIR_DECODE, MAP_FULL,   8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
    '{1'b0, DIR_DECODE, MAP_FULL,   8'd1,   1'b0, 1'b1, 8'd128, 1'b0},
    '{1'b1, DIR_DECODE, MAP_SPARSE, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
    '{1'b0, DIR_DECODE, MAP_SPARSE, 8'd3,   1'b1, 1'b1, 8'd255, 1'b0},
    '{1'b0, DIR_DECODE, MAP_SPARSE, 8'd4,   1'b0, 1'b1, 8'd0,   1'b1},
    '{1'b0, DIR_DECODE, MAP_SPARSE, 8'd255, 1'b0, 1'b1, 8'd0,   1'b1},
    '{1'b1, DIR_ENCODE, MAP_SPARSE, 8'd127, 1'b0, 1'b1, 8'd2,   1'b0},
    '{1'b0, DIR_ENCODE, MAP_SPARSE, 8'd1,   1'b0, 1'b1, 8'd0,   1'b1},
    '{1'b0, DIR_ENCODE, MAP_SPARSE, 8'd192, 1'b0, 1'b1, 8'd3,   1'b0},
    '{1'b0, DIR_ENCODE, MAP_SPARSE, 8'd128, 1'b1, 1'b1, 8'd0,   1'b1},
    '{1'b1, DIR_ENCODE, MAP_NONE,   8'd0,   1'b1, 1'b1, 8'd0,   1'b1},
    '{1'b0, DIR_ENCODE, MAP_NONE,   8'd255, 1'b0, 1'b1, 8'd0,   1'b1},
    '{1'b1, DIR_DECODE, MAP_NONE,   8'd0,   1'b0, 1'b1, 8'd0,   1'b1},
    '{1'b1, DIR_DECODE, MAP_FULL,   8'd0,   1'b1, 1'b1, 8'd0,   1'b0},
    '{1'b0, DIR_DECODE, MAP_FULL,   8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{1'b1, DIR_ENCODE, MAP_ONE,    8'd200, 1'b1, 1'b1, 8'd0,   1'b0},
    '{1'b0, DIR_ENCODE, MAP_ONE,    8'd199, 1'b0, 1'b1, 8'd0,   1'b1}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mtf_in_if  item_ch ();
  mtf_out_if result_ch ();

  move_to_front_coder_top #(
    .ALPHABET_SIZE(ALPHA)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the list and of the configuration it reloads from.
  logic [SYM_W-1:0] order_list [256];
  int               order_len;
  logic             coder_dir;
  logic [255:0]     present_map;

  code_t pending_codes [$];
  int    mismatches;
  int    send_idle_pct;
  int    recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // Rebuild the list from the presence map in ascending symbol order.
  function automatic void reload_order();
    order_len = 0;
    for (int s = 0; s < 256; s++) order_list[s] = '0;
    for (int s = 0; s < ALPHA; s++) begin
      if (present_map[s]) begin
        order_list[order_len] = SYM_W'(s);
        order_len++;
      end
    end
  endfunction

  // Code one word and move the used entry to the front.
  function automatic code_t mtf_code(logic [SYM_W-1:0] v, logic sob);
    code_t            r;
    int               pos;
    logic [SYM_W-1:0] sym;
    r   = '0;
    r.not_found = 1'b1;
    pos = -1;
    if (sob) reload_order();
    if (coder_dir == DIR_ENCODE) begin
      for (int k = 0; k < order_len; k++) begin
        if (pos < 0 && order_list[k] == v) pos = k;
      end
    end else if (int'(v) < order_len) begin
      pos = int'(v);
    end
    if (pos >= 0) begin
      sym = order_list[pos];
      r.coded_value = (coder_dir == DIR_ENCODE) ? SYM_W'(pos) : sym;
      r.not_found   = 1'b0;
      for (int k = pos; k > 0; k--) order_list[k] = order_list[k-1];
      order_list[0] = sym;
    end
    return r;
  endfunction

  // One register write; the bench copy follows it at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DIRECTION: coder_dir          = data[0];
      REG_MAP_0:     present_map[63:0]    = data;
      REG_MAP_1:     present_map[127:64]  = data;
      REG_MAP_2:     present_map[191:128] = data;
      REG_MAP_3:     present_map[255:192] = data;
      default: ;
    endcase
  endtask

  // Wait until every result word is back, then write all registers and one
  // unused index.
  task automatic reconfigure(logic dir, logic [255:0] map);
    logic [CFG_DATA_W-1:0] dir_word;
    item_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    dir_word    = {$urandom, $urandom};
    dir_word[0] = dir;
    write_reg(REG_DIRECTION, dir_word);
    write_reg(REG_MAP_0, map[63:0]);
    write_reg(REG_MAP_1, map[127:64]);
    write_reg(REG_MAP_2, map[191:128]);
    write_reg(REG_MAP_3, map[255:192]);
    write_reg(CFG_IDX_W'($urandom_range(7, int'(REG_MAP_3) + 1)), {$urandom, $urandom});
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Offer one word after a random gap and record its expected result once
  // it is taken. Called at a rising edge; returns at the accepting edge.
  task automatic send_word(logic [SYM_W-1:0] v, logic sob, logic typed, code_t typed_code);
    code_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_ch.valid          <= 1'b1;
    item_ch.item_value     <= v;
    item_ch.start_of_block <= sob;
    do @(posedge clk); while (!item_ch.ready);
    predicted = mtf_code(v, sob);
    pending_codes.insert(pending_codes.size(), typed ? typed_code : predicted);
  endtask

  // Result side: random stalls and a field-by-field check of each word.
  initial begin
    code_t want;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result word with nothing expected: value %0d not_found %b",
                     $realtime, result_ch.coded_value, result_ch.not_found);
        end else begin
          want = pending_codes.pop_front();
          if (want.coded_value !== result_ch.coded_value ||
              want.not_found !== result_ch.not_found) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch: expected value %0d not_found %b, got value %0d not_found %b",
                       $realtime, want.coded_value, want.not_found,
                       result_ch.coded_value, result_ch.not_found);
          end
        end
      end
      result_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [255:0]     map;
    logic [SYM_W-1:0] v;
    logic             sob;
    int               pos;
    directed_row_t    row;

    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_index              <= '0;
    cfg_data               <= '0;
    item_ch.valid          <= 1'b0;
    item_ch.item_value     <= '0;
    item_ch.start_of_block <= 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    coder_dir      = DIR_ENCODE;
    present_map    = MAP_FULL;
    reload_order();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.set_cfg) reconfigure(row.dir, row.map);
      send_word(row.value, row.sob, row.typed, {row.code, row.nf});
    end

    // Random phases, each with its own idling pattern.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;          recv_stall_pct = 0;          end
        1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
        2: begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
        default: begin send_idle_pct = IDLE_LIGHT; recv_stall_pct = IDLE_LIGHT; end
      endcase
      for (int blk = 0; blk < N_BLOCKS; blk++) begin
        // New map and direction now and then; the list only follows the map
        // at the next start of block.
        if (blk == 0 || $urandom_range(1) == 1) begin
          for (int w = 0; w < 8; w++) map[32*w +: 32] = $urandom;
          case ($urandom_range(9))
            0: map = MAP_FULL;
            1: map = MAP_NONE;
            2, 3, 4: ;
            5, 6: for (int w = 0; w < 8; w++) map[32*w +: 32] &= $urandom & $urandom;
            7: begin
              map = MAP_NONE;
              map[$urandom_range(ALPHA - 1)] = 1'b1;
            end
            default: for (int w = 0; w < 4; w++) if ($urandom_range(1) == 1) map[64*w +: 64] = '0;
          endcase
          reconfigure(1'($urandom_range(1)), map);
        end
        for (int k = 0; k < BLOCK_WORDS; k++) begin
          sob = (k == 0) ? ($urandom_range(99) < 60) : ($urandom_range(99) < 3);
          // Mostly symbols or positions that hit the list, often near the
          // front; the rest is uniform noise.
          if (order_len == 0 || $urandom_range(99) < 10) begin
            v = SYM_W'($urandom_range(255));
          end else begin
            pos = ($urandom_range(99) < 35) ?
                  $urandom_range(order_len > 4 ? 3 : order_len - 1) :
                  $urandom_range(order_len - 1);
            v = (coder_dir == DIR_ENCODE) ? order_list[pos] : SYM_W'(pos);
          end
          send_word(v, sob, 1'b0, '0);
        end
      end
    end

    // Drain and look for stray result words.
    item_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* move_to_front_coder_top.f */
rtl/mtf_pkg.sv
rtl/mtf_in_if.sv
rtl/mtf_out_if.sv
rtl/mtf_cfg_regs.sv
rtl/mtf_ctrl.sv
rtl/mtf_datapath.sv
rtl/move_to_front_coder_top.sv
dv/tb_top.sv
